// File: src/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared constants, types and register codes of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Geometry limits
  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int DIM_W        = 13;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int STORE_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  // Pixel arithmetic
  localparam int NUM_CH  = 4;
  localparam int CH_W    = 8;
  localparam int PAIR_W  = CH_W + 1;
  localparam int SUM_W   = 10;
  localparam int WORD_W  = NUM_CH * SUM_W;

  // Configuration register codes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // Frame geometry derived from the configuration registers
  typedef struct packed {
    logic              restart;
    logic              w_one;
    logic              h_one;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;
    logic [ADDR_W-1:0] dcol_last;
    logic [ROW_W-2:0]  drow_last;
  } geom_t;

endpackage

// File: src/rbd_pixel_if.sv
// ----------------------------------------------------------------------------
// rbd_pixel_if
// Valid/ready channel carrying one RGBA8 input pixel per transaction.
// ----------------------------------------------------------------------------
interface rbd_pixel_if;
  import rbd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);

endinterface

// File: src/rbd_result_if.sv
// ----------------------------------------------------------------------------
// rbd_result_if
// Valid/ready channel carrying one downsampled RGBA8 pixel per transaction.
// ----------------------------------------------------------------------------
interface rbd_result_if;
  import rbd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic            frame_end;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                  output ready);

endinterface

// File: src/rgba_box_downsample_2x.sv
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x
// Streaming 2x2 box-filter downsampler for RGBA8 pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the result side stalls it and, on the pixel
// that completes a 2x2 square, gives the per-channel rounded mean (sum+2)/4;
// the last result of a frame carries frame_end. Stage 1 holds a result while
// the line store (synchronous RAM) is read, then the output register holds
// it, which lets the next pixel be taken while a result waits. The line store
// holds the pair sums of the top row of each square, 2048 words of 40 bits;
// it is never cleared, since a bottom row only reads entries its top row has
// written. Width and height registers are to be written only while the block
// is idle, which the block does not enforce; a write restarts the frame.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] reg_index,
  input  logic [rbd_pkg::DIM_W-1:0]     write_data,
  rbd_pixel_if.sink                     pixel,
  rbd_result_if.source                  result
);
  import rbd_pkg::*;

  geom_t geom;

  // Stage 0: raster position, left pixel and horizontal pair sums
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [CH_W-1:0]   left [NUM_CH];
  logic [CH_W-1:0]   px   [NUM_CH];
  logic [PAIR_W-1:0] pair [NUM_CH];
  logic [ADDR_W-1:0] k;
  logic              accept;
  logic              pair_done;
  logic              emit;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              end_flag;

  // Stage 1: waits for the line-store word
  logic              s1_valid;
  logic [PAIR_W-1:0] s1_pair [NUM_CH];
  logic              s1_use_top;
  logic              s1_end;
  logic [ADDR_W-1:0] s1_k;
  logic              s1_advance;
  logic [CH_W-1:0]   res [NUM_CH];

  // Output register
  logic              out_valid;
  logic [CH_W-1:0]   out_px [NUM_CH];
  logic              out_end;

  rbd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .geom         (geom)
  );

  rbd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake: stage 1 moves when the output register is free or drained
  assign s1_advance  = !out_valid || result.ready;
  assign pixel.ready = !s1_valid || s1_advance;
  assign accept      = pixel.valid && pixel.ready;

  assign px[0] = pixel.in_red;
  assign px[1] = pixel.in_green;
  assign px[2] = pixel.in_blue;
  assign px[3] = pixel.in_alpha;

  // Form the pair sum; a one-pixel-wide image doubles the pixel
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (geom.w_one) begin
        pair[i] = {px[i], 1'b0};
      end else begin
        pair[i] = PAIR_W'(left[i]) + PAIR_W'(px[i]);
      end
      ram_wdata[i*SUM_W +: SUM_W] = SUM_W'(pair[i]);
    end
  end

  assign k         = col[COL_W-1:1];
  assign pair_done = geom.w_one || col[0];
  assign emit      = accept && pair_done && (geom.h_one || row[0]);
  assign ram_we    = accept && pair_done && !geom.h_one && !row[0] &&
                     (row != geom.row_last);
  assign end_flag  = (k == geom.dcol_last) && (row[ROW_W-1:1] == geom.drow_last);

  // Re-read the held square's entry while stage 1 is stalled
  assign ram_raddr = accept ? k : s1_k;

  // Advance the raster position; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (geom.restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == geom.col_last) begin
        col <= '0;
        row <= (row == geom.row_last) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Hold the even-column pixel for its partner
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        left[i] <= '0;
      end
    end else if (accept && !geom.w_one && !col[0]) begin
      for (int i = 0; i < NUM_CH; i++) begin
        left[i] <= px[i];
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= emit;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pair    <= pair;
      s1_use_top <= !geom.h_one;
      s1_end     <= end_flag;
      s1_k       <= k;
    end
  end

  // Add the top-row pair sum and round
  always_comb begin
    logic [SUM_W-1:0] top;
    logic [SUM_W:0]   sum;
    for (int i = 0; i < NUM_CH; i++) begin
      top    = s1_use_top ? ram_rdata[i*SUM_W +: SUM_W] : SUM_W'(s1_pair[i]);
      sum    = (SUM_W + 1)'(top) + (SUM_W + 1)'(s1_pair[i]) + (SUM_W + 1)'(2);
      res[i] = sum[CH_W+1:2];
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_px  <= res;
      out_end <= s1_end;
    end
  end

  assign result.valid     = out_valid;
  assign result.out_red   = out_px[0];
  assign result.out_green = out_px[1];
  assign result.out_blue  = out_px[2];
  assign result.out_alpha = out_px[3];
  assign result.frame_end = out_end;

  // Raster position never leaves the frame
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    col <= geom.col_last)
    else $error("column beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    row <= geom.row_last)
    else $error("row beyond frame height");

  // Input is held off only by a stalled stage 1
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> s1_valid && !s1_advance)
    else $error("input stalled without a pending result");

  // No line-store write while a read for a held square is outstanding
  a_no_write_on_hold: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !(s1_valid && !s1_advance))
    else $error("line store written during a stage 1 hold");

  // A result leaving stage 1 lands in the output register
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance |=> out_valid)
    else $error("result lost between stage 1 and output");

endmodule

// File: src/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/rbd_cfg.sv
// ----------------------------------------------------------------------------
// rbd_cfg
// Width and height registers and the frame geometry derived from them.
// ----------------------------------------------------------------------------
module rbd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] reg_index,
  input  logic [rbd_pkg::DIM_W-1:0]     write_data,
  output rbd_pkg::geom_t                geom
);
  import rbd_pkg::*;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] dw;
  logic [DIM_W-1:0] dh;

  // Hold the raw register values
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_W'(1);
      height_reg <= DIM_W'(1);
    end else if (write_enable) begin
      case (reg_index)
        REG_WIDTH:  width_reg  <= write_data;
        REG_HEIGHT: height_reg <= write_data;
        default: ;
      endcase
    end
  end

  // Clamp to the supported range, zero acting as one
  always_comb begin
    if (width_reg == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_reg > DIM_W'(HEIGHT_LIMIT)) begin
      h_eff = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_reg;
    end
    dw = (w_eff >> 1) == '0 ? DIM_W'(1) : (w_eff >> 1);
    dh = (h_eff >> 1) == '0 ? DIM_W'(1) : (h_eff >> 1);
  end

  // Publish the geometry; any listed register write restarts the frame
  always_comb begin
    geom.restart   = write_enable && (reg_index == REG_WIDTH || reg_index == REG_HEIGHT);
    geom.w_one     = (w_eff == DIM_W'(1));
    geom.h_one     = (h_eff == DIM_W'(1));
    geom.col_last  = COL_W'(w_eff - DIM_W'(1));
    geom.row_last  = ROW_W'(h_eff - DIM_W'(1));
    geom.dcol_last = ADDR_W'(dw - DIM_W'(1));
    geom.drow_last = (ROW_W - 1)'(dh - DIM_W'(1));
  end

endmodule

// File: tb/sv/tb_rgba_box_downsample_2x.sv
// ----------------------------------------------------------------------------
// tb_rgba_box_downsample_2x
// Self-checking bench for the streaming 2x2 box downsampler.
// ----------------------------------------------------------------------------
// Pushes RGBA8 pixel frames through the pixel channel and predicts every
// downsampled pixel with a cycle-free model of the line store, the held left
// pixel and the raster position. Each result taken from the result channel is
// compared channel by channel, frame_end included, against the oldest
// prediction. Directed tests cover the reset geometry, rounding, dropped edge
// pixels, zero and oversized dimensions, unused register indexes and frame
// restarts; random frames follow, with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_rgba_box_downsample_2x;
  timeunit 1ns;
  timeprecision 1ps;

  import rbd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int GAP_MAX      = 14;
  localparam int RANDOM_ITEMS = 250;
  localparam int CLAMP_ITEMS  = 32;
  localparam int MAX_REPORTS  = 40;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Indexes past the register list; writes to them change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Channel 0 is red, then green, blue, alpha
  typedef logic [NUM_CH-1:0][CH_W-1:0] rgba_t;

  typedef struct packed {
    rgba_t mean;
    logic  frame_end;
  } square_t;

  logic                 clk;
  logic                 rst;
  logic                 write_enable;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DIM_W-1:0]     write_data;

  rbd_pixel_if  pixel_ch ();
  rbd_result_if result_ch ();

  rgba_box_downsample_2x uut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pixel        (pixel_ch),
    .result       (result_ch)
  );

  // Predictor state
  logic [WORD_W-1:0] top_row_sums [STORE_DEPTH];
  rgba_t             held_left;
  logic [COL_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;

  square_t pending_means [$];
  int      mismatches   = 0;
  int      pixels_sent  = 0;
  bit      calm         = 1'b0;
  bit      tx_gaps_on   = 1'b1;
  bit      rx_stalls_on = 1'b1;
  bit      drive_valid  = 1'b0;

  string chan_name [NUM_CH] = '{"red", "green", "blue", "alpha"};

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic int frame_pixels();
    return clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, HEIGHT_LIMIT);
  endfunction

  function automatic void reset_predictor();
    width_reg  = DIM_W'(1);
    height_reg = DIM_W'(1);
    held_left  = '0;
    col_pos    = '0;
    row_pos    = '0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [DIM_W-1:0] data);
    case (idx)
      REG_WIDTH: begin
        width_reg = data;
        col_pos   = '0;
        row_pos   = '0;
      end
      REG_HEIGHT: begin
        height_reg = data;
        col_pos    = '0;
        row_pos    = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Advance the raster position by one pixel; return 1 when it completes a square
  function automatic bit average_square(input rgba_t px, output square_t res);
    int w, h, dw, dh, c, r, k, y;
    int pair [NUM_CH];
    logic [WORD_W-1:0] word;
    bit paired, emit;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, HEIGHT_LIMIT);
    dw = (w / 2 > 0) ? w / 2 : 1;
    dh = (h / 2 > 0) ? h / 2 : 1;
    c = int'(col_pos);
    r = int'(row_pos);
    k = 0;
    y = 0;
    paired = 1'b0;
    emit = 1'b0;
    res = '0;
    word = '0;

    // Form the horizontal pair; a single-column image doubles the pixel
    if (w == 1) begin
      for (int ch = 0; ch < NUM_CH; ch++) pair[ch] = 2 * int'(px[ch]);
      paired = 1'b1;
    end else if (c % 2 == 1) begin
      for (int ch = 0; ch < NUM_CH; ch++) pair[ch] = int'(held_left[ch]) + int'(px[ch]);
      k = c / 2;
      paired = 1'b1;
    end else begin
      held_left = px;
    end

    // Combine vertically: store on the top row, average on the bottom row
    if (paired) begin
      if (h == 1) begin
        for (int ch = 0; ch < NUM_CH; ch++) res.mean[ch] = CH_W'((2 * pair[ch] + 2) >> 2);
        emit = 1'b1;
      end else if (r % 2 == 0) begin
        if (r != h - 1) begin
          for (int ch = 0; ch < NUM_CH; ch++) word[ch*SUM_W +: SUM_W] = SUM_W'(pair[ch]);
          top_row_sums[k] = word;
        end
      end else begin
        word = top_row_sums[k];
        for (int ch = 0; ch < NUM_CH; ch++)
          res.mean[ch] = CH_W'((int'(word[ch*SUM_W +: SUM_W]) + pair[ch] + 2) >> 2);
        y = r / 2;
        emit = 1'b1;
      end
      if (emit) res.frame_end = (k == dw - 1) && (y == dh - 1);
    end

    // Step the raster position, wrapping at the end of the frame
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = COL_W'(c);
    row_pos = ROW_W'(r);
    return emit;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_square();
    square_t got, want;
    got.mean = {result_ch.out_alpha, result_ch.out_blue, result_ch.out_green,
                result_ch.out_red};
    got.frame_end = result_ch.frame_end;
    if (pending_means.size() == 0) begin
      report_mismatch("result transaction with no prediction outstanding");
    end else begin
      want = pending_means.pop_front();
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (got.mean[ch] !== want.mean[ch])
          report_mismatch($sformatf("%s got %0d expected %0d", chan_name[ch],
                                    got.mean[ch], want.mean[ch]));
      end
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end got %0b expected %0b", got.frame_end,
                                  want.frame_end));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) check_square();
  end

  // Result side back-pressure: random stall bursts, in stretches
  initial begin
    int hold;
    int span;
    hold = 0;
    span = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = 256;
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      span--;
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else if (!calm && rx_stalls_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, GAP_MAX) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("rgba_box_downsample_2x verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic rgba_t rgba(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                 input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
    return {a, b, g, r};
  endfunction

  task automatic lower_valid();
    if (drive_valid) begin
      pixel_ch.valid <= 1'b0;
      drive_valid = 1'b0;
    end
  endtask

  // Offer one pixel, hold it until taken, then maybe idle for a burst
  task automatic send_pixel(input rgba_t px);
    square_t due;
    pixel_ch.valid    <= 1'b1;
    drive_valid = 1'b1;
    pixel_ch.in_red   <= px[0];
    pixel_ch.in_green <= px[1];
    pixel_ch.in_blue  <= px[2];
    pixel_ch.in_alpha <= px[3];
    do @(posedge clk); while (!pixel_ch.ready);
    pixels_sent++;
    if (average_square(px, due)) pending_means.insert(pending_means.size(), due);
    if (!calm && tx_gaps_on && $urandom_range(0, 3) == 0) begin
      lower_valid();
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(rgba_t'($urandom));
  endtask

  // Stop sending and hold until every predicted result has been taken
  task automatic drain_results();
    lower_valid();
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  // Drain, then let pixels that give no result clear the pipeline
  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic random_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    set_geometry(w, h);
    send_random_pixels(frame_pixels());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset geometry is 1x1: every pixel is its own frame
  task automatic test_reset_geometry();
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgba(8'h55, 8'hAA, 8'h0F, 8'hF0));
  endtask

  // Rounding of (sum+2)/4 at the channel extremes
  task automatic test_rounding();
    set_geometry(DIM_W'(2), DIM_W'(2));
    send_pixel(rgba(8'h00, 8'h00, 8'hFF, 8'h01));
    send_pixel(rgba(8'h00, 8'h00, 8'hFF, 8'h00));
    send_pixel(rgba(8'h00, 8'h01, 8'hFF, 8'h00));
    send_pixel(rgba(8'h01, 8'h01, 8'hFE, 8'h00));
    send_pixel(rgba(8'hFF, 8'h00, 8'h00, 8'h80));
    send_pixel(rgba(8'hFF, 8'h00, 8'h01, 8'h7F));
    send_pixel(rgba(8'hFF, 8'h00, 8'h01, 8'h80));
    send_pixel(rgba(8'hFF, 8'h00, 8'h00, 8'h7F));
  endtask

  // Trailing odd column and row give nothing
  task automatic test_dropped_edges();
    random_frame(DIM_W'(3), DIM_W'(3));
    random_frame(DIM_W'(5), DIM_W'(2));
    random_frame(DIM_W'(2), DIM_W'(5));
  endtask

  // Zero dimensions act as one
  task automatic test_zero_dims();
    random_frame(DIM_W'(0), DIM_W'(0));
    random_frame(DIM_W'(0), DIM_W'(4));
    random_frame(DIM_W'(6), DIM_W'(0));
  endtask

  // Writes to spare indexes must not restart the frame
  task automatic test_spare_index();
    set_geometry(DIM_W'(4), DIM_W'(2));
    send_random_pixels(3);
    settle();
    write_reg(REG_SPARE_A, DIM_W'($urandom));
    write_reg(REG_SPARE_B, '1);
    send_random_pixels(5);
  endtask

  // Rewriting either register mid-frame restarts the frame
  task automatic test_restart();
    set_geometry(DIM_W'(4), DIM_W'(4));
    send_random_pixels(6);
    settle();
    write_reg(REG_WIDTH, DIM_W'(4));
    send_random_pixels(16);
    send_random_pixels(9);
    settle();
    write_reg(REG_HEIGHT, DIM_W'(4));
    send_random_pixels(16);
  endtask

  // Oversized dimensions clamp to the limits; run the opening stretch of each
  task automatic test_size_limits();
    set_geometry('1, DIM_W'(0));
    send_random_pixels(CLAMP_ITEMS);
    set_geometry(DIM_W'(1), '1);
    send_random_pixels(CLAMP_ITEMS);
    set_geometry(DIM_W'(MAX_WIDTH), DIM_W'(0));
    send_random_pixels(CLAMP_ITEMS);
  endtask

  // Random geometry, mostly whole frames, some cut short
  task automatic test_random_frames();
    int start, iter, sel, n, half;
    logic [DIM_W-1:0] w, h;
    start = pixels_sent;
    iter = 0;
    while (pixels_sent - start < RANDOM_ITEMS || iter < 4) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        w = DIM_W'($urandom_range(0, 2));
        h = DIM_W'($urandom_range(0, 2));
      end else if (sel < 16) begin
        w = DIM_W'($urandom_range(1, 12));
        h = DIM_W'($urandom_range(1, 12));
      end else begin
        w = DIM_W'($urandom_range(13, 40));
        h = DIM_W'($urandom_range(1, 8));
      end
      set_geometry(w, h);
      n = frame_pixels();
      if (iter == 3) begin
        // Pause the source mid-frame until every result is out
        half = n / 2;
        send_random_pixels(half);
        drain_results();
        send_random_pixels(n - half);
      end else begin
        if (n > 1 && $urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
        send_random_pixels(n);
      end
      iter++;
    end
    tx_gaps_on = 1'b1;
  endtask

  // Back-to-back transactions with no idling on either side
  task automatic test_steady_stream();
    calm = 1'b1;
    random_frame(DIM_W'(8), DIM_W'(6));
    random_frame(DIM_W'(16), DIM_W'(4));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst               <= 1'b1;
    write_enable      <= 1'b0;
    reg_index         <= REG_WIDTH;
    write_data        <= '0;
    pixel_ch.valid    <= 1'b0;
    pixel_ch.in_red   <= '0;
    pixel_ch.in_green <= '0;
    pixel_ch.in_blue  <= '0;
    pixel_ch.in_alpha <= '0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_geometry();
    test_rounding();
    test_dropped_edges();
    test_zero_dims();
    test_spare_index();
    test_restart();
    test_size_limits();
    test_random_frames();
    test_steady_stream();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("rgba_box_downsample_2x verification clean");
    end else begin
      $display("rgba_box_downsample_2x verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rbd_pkg.sv
src/rbd_pixel_if.sv
src/rbd_result_if.sv
src/rbd_ram.sv
src/rbd_cfg.sv
src/rgba_box_downsample_2x.sv
tb/sv/tb_rgba_box_downsample_2x.sv
